>>> src/olsd_pkg.sv
// Shared types, sizes and the control store for the ordered list unit.
// Depends on nothing; imported by olsd_ram users and the top level.
`timescale 1ns / 1ps

package olsd_pkg;

   localparam int CAPACITY   = 16;
   localparam int VALUE_W    = 64;
   localparam int FUNC_W     = 3;
   localparam int INDEX_W    = 4;
   localparam int STATUS_W   = 2;
   localparam int POSITION_W = 4;
   localparam int COUNT_W    = 5;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int CMP_W      = (CNT_W > INDEX_W) ? CNT_W + 1 : INDEX_W + 1;

   // request codes
   localparam logic [FUNC_W-1:0] FN_APPEND    = 3'd0;
   localparam logic [FUNC_W-1:0] FN_POP       = 3'd1;
   localparam logic [FUNC_W-1:0] FN_REMOVE_AT = 3'd2;
   localparam logic [FUNC_W-1:0] FN_REMOVE_V  = 3'd3;
   localparam logic [FUNC_W-1:0] FN_FIND      = 3'd4;
   localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd5;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_MISS  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_APP0, S_APP1, S_POP0, S_POP1, S_RAT0, S_CMP0, S_CMP1,
      S_CMP_DONE, S_SCN0, S_SCN1, S_SCN2, S_HIT, S_HIT1, S_FIND_OK,
      S_CLR, S_FAIL_FULL, S_FAIL_MISS, S_FAIL_RANGE, S_EMIT
   } step_type;

   typedef enum logic [2:0] {
      SEQ_NEXT, SEQ_JUMP, SEQ_BRANCH, SEQ_HOLD, SEQ_DISPATCH
   } seq_type;

   typedef enum logic [2:0] {
      C_FULL, C_EMPTY, C_RANGE, C_SCAN_END, C_LAST, C_HIT, C_IS_FIND, C_OUT_FREE
   } cond_type;

   typedef struct packed {
      seq_type    seq;
      cond_type   cond;
      step_type   target;
      logic       wr_tail;    // write request value at the tail
      logic       wr_shift;   // write read data one slot down
      logic       rd_cur;     // read entry at pointer
      logic       rd_nxt;     // read entry after pointer
      logic       ptr_idx;    // load pointer and position from request index
      logic       ptr_inc;
      logic       pos_cur;    // capture pointer as position
      logic       cnt_inc;
      logic       cnt_dec;
      logic       cnt_clr;
      logic       set_found;
      logic       st_set;     // load failure status, clear position and found flag
      status_type st;
      logic       emit;
   } ctrl_type;

   // Entry step of each request's routine.
   function automatic step_type dispatch(logic [FUNC_W-1:0] func);
      step_type s;
      case (func)
         FN_APPEND:    s = S_APP0;
         FN_POP:       s = S_POP0;
         FN_REMOVE_AT: s = S_RAT0;
         FN_REMOVE_V:  s = S_SCN0;
         FN_FIND:      s = S_SCN0;
         FN_CLEAR:     s = S_CLR;
         default:      s = S_EMIT;
      endcase
      return s;
   endfunction

   // Control store: one word per step.
   function automatic ctrl_type ucode(step_type s);
      ctrl_type w;
      w        = '0;
      w.seq    = SEQ_NEXT;
      w.cond   = C_FULL;
      w.target = S_IDLE;
      w.st     = ST_OK;
      case (s)
         S_IDLE: begin
            w.seq = SEQ_DISPATCH;
         end
         S_APP0: begin
            w.seq = SEQ_BRANCH; w.cond = C_FULL; w.target = S_FAIL_FULL;
         end
         S_APP1: begin
            w.seq = SEQ_JUMP; w.target = S_EMIT; w.wr_tail = 1'b1; w.cnt_inc = 1'b1;
         end
         S_POP0: begin
            w.seq = SEQ_BRANCH; w.cond = C_EMPTY; w.target = S_FAIL_MISS;
         end
         S_POP1: begin
            w.seq = SEQ_JUMP; w.target = S_EMIT; w.cnt_dec = 1'b1;
         end
         S_RAT0: begin
            w.seq = SEQ_BRANCH; w.cond = C_RANGE; w.target = S_FAIL_RANGE;
            w.ptr_idx = 1'b1;
         end
         S_CMP0: begin
            w.seq = SEQ_BRANCH; w.cond = C_LAST; w.target = S_CMP_DONE;
            w.rd_nxt = 1'b1;
         end
         S_CMP1: begin
            w.seq = SEQ_JUMP; w.target = S_CMP0; w.wr_shift = 1'b1; w.ptr_inc = 1'b1;
         end
         S_CMP_DONE: begin
            w.seq = SEQ_JUMP; w.target = S_EMIT; w.cnt_dec = 1'b1;
         end
         S_SCN0: begin
            w.seq = SEQ_BRANCH; w.cond = C_SCAN_END; w.target = S_FAIL_MISS;
            w.rd_cur = 1'b1; w.pos_cur = 1'b1;
         end
         S_SCN1: begin
            w.seq = SEQ_BRANCH; w.cond = C_HIT; w.target = S_HIT;
         end
         S_SCN2: begin
            w.seq = SEQ_JUMP; w.target = S_SCN0; w.ptr_inc = 1'b1;
         end
         S_HIT: begin
            w.seq = SEQ_BRANCH; w.cond = C_IS_FIND; w.target = S_FIND_OK;
         end
         S_HIT1: begin
            w.seq = SEQ_JUMP; w.target = S_CMP0;
         end
         S_FIND_OK: begin
            w.seq = SEQ_JUMP; w.target = S_EMIT; w.set_found = 1'b1;
         end
         S_CLR: begin
            w.seq = SEQ_JUMP; w.target = S_EMIT; w.cnt_clr = 1'b1;
         end
         S_FAIL_FULL: begin
            w.seq = SEQ_JUMP; w.target = S_EMIT; w.st_set = 1'b1; w.st = ST_FULL;
         end
         S_FAIL_MISS: begin
            w.seq = SEQ_JUMP; w.target = S_EMIT; w.st_set = 1'b1; w.st = ST_MISS;
         end
         S_FAIL_RANGE: begin
            w.seq = SEQ_JUMP; w.target = S_EMIT; w.st_set = 1'b1; w.st = ST_RANGE;
         end
         S_EMIT: begin
            w.seq = SEQ_HOLD; w.cond = C_OUT_FREE; w.target = S_IDLE; w.emit = 1'b1;
         end
         default: begin
            w.seq = SEQ_JUMP; w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

>>> src/olsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module olsd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

>>> src/ordered_list_with_search_delete_unit.sv
// Ordered list unit: top level with the microcoded sequencer and datapath.
// Depends on olsd_pkg and olsd_ram.
`timescale 1ns / 1ps

// The unit keeps an ordered list of up to CAPACITY 64-bit values in a RAM
// and serves one request at a time: append, remove last, remove at index,
// remove value, find value and clear, each answered by exactly one result
// with status, found flag, position and the count after the request. A
// request is taken only while the sequencer sits at its idle step; a
// finished result waits in the output register, so the next request is
// taken while the previous result is still pending. Timing is set by the
// single RAM read port walked by the microprogram. An unused code goes
// straight to the emit step; clear, append, remove last and the failed checks
// of append, remove last and remove at index pass through their own steps
// before it. A search reads, compares and advances for each entry in turn, a
// find answering at the first hit and a miss after the last entry; remove
// value answers a miss the same way. A removal closes the gap by shifting
// each later entry one slot down, for remove at index from the given index
// and for remove value from the hit position. A result that finds the output
// register still occupied holds the sequencer at its emit step for as long
// as it waits. The sequencer returns to its idle step on the same edge that
// loads the result, so the next request can be accepted while that result
// is shown. The list is empty after reset; no clearing pass is needed
// because entries at or above the count never affect a result.
module ordered_list_with_search_delete_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [olsd_pkg::FUNC_W-1:0]    req_func,
   input  logic [olsd_pkg::VALUE_W-1:0]   req_value,
   input  logic [olsd_pkg::INDEX_W-1:0]   req_index,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [olsd_pkg::STATUS_W-1:0]  rsp_status,
   output logic                           rsp_found,
   output logic [olsd_pkg::POSITION_W-1:0] rsp_position,
   output logic [olsd_pkg::COUNT_W-1:0]   rsp_count
);

   import olsd_pkg::*;

   // sequencer and request registers
   step_type                upc_ff, upc_in;
   logic [FUNC_W-1:0]       func_ff, func_in;
   logic [VALUE_W-1:0]      value_ff, value_in;
   logic [INDEX_W-1:0]      index_ff, index_in;

   // datapath registers
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        ptr_ff, ptr_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic                    found_ff, found_in;
   status_type              status_ff, status_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [POSITION_W-1:0]   rsp_position_ff, rsp_position_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   ctrl_type                ctrl;
   logic                    accept;
   logic                    out_free;
   logic                    cond_true;
   logic [CNT_W-1:0]        ptr_nxt;
   logic                    ram_wr_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [VALUE_W-1:0]      ram_wr_data;
   logic                    ram_rd_en;
   logic [ADDR_W-1:0]       ram_rd_addr;
   logic [VALUE_W-1:0]      ram_rd_data;

   assign ctrl      = ucode(upc_ff);
   assign req_ready = (upc_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ptr_nxt   = ptr_ff + 1'b1;

   // Condition select for branches and holds.
   always_comb begin
      case (ctrl.cond)
         C_FULL:     cond_true = ({1'b0, count_ff} >= (CNT_W + 1)'(CAPACITY));
         C_EMPTY:    cond_true = (count_ff == '0);
         C_RANGE:    cond_true = (CMP_W'(index_ff) >= CMP_W'(count_ff));
         C_SCAN_END: cond_true = (ptr_ff >= count_ff);
         C_LAST:     cond_true = ((ptr_ff + (CNT_W + 1)'(1)) >= {1'b0, count_ff});
         C_HIT:      cond_true = (ram_rd_data == value_ff);
         C_IS_FIND:  cond_true = (func_ff == FN_FIND);
         C_OUT_FREE: cond_true = out_free;
         default:    cond_true = 1'b0;
      endcase
   end

   // Next step.
   always_comb begin
      case (ctrl.seq)
         SEQ_NEXT:     upc_in = step_type'(upc_ff + 5'd1);
         SEQ_JUMP:     upc_in = ctrl.target;
         SEQ_BRANCH:   upc_in = cond_true ? ctrl.target : step_type'(upc_ff + 5'd1);
         SEQ_HOLD:     upc_in = cond_true ? ctrl.target : upc_ff;
         SEQ_DISPATCH: upc_in = accept ? dispatch(req_func) : upc_ff;
         default:      upc_in = S_IDLE;
      endcase
   end

   // Datapath updates driven by the control word.
   always_comb begin
      func_in         = func_ff;
      value_in        = value_ff;
      index_in        = index_ff;
      count_in        = count_ff;
      ptr_in          = ptr_ff;
      pos_in          = pos_ff;
      found_in        = found_ff;
      status_in       = status_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      rsp_count_in    = rsp_count_ff;

      // latch the request and start from a clean result
      if (accept) begin
         func_in   = req_func;
         value_in  = req_value;
         index_in  = req_index;
         ptr_in    = '0;
         pos_in    = '0;
         found_in  = 1'b0;
         status_in = ST_OK;
      end

      if (ctrl.ptr_idx) begin
         ptr_in = CNT_W'(index_ff);
         pos_in = CNT_W'(index_ff);
      end
      if (ctrl.pos_cur)   pos_in = ptr_ff;
      if (ctrl.ptr_inc)   ptr_in = ptr_nxt;
      if (ctrl.cnt_inc)   count_in = count_ff + 1'b1;
      if (ctrl.cnt_dec)   count_in = count_ff - 1'b1;
      if (ctrl.cnt_clr)   count_in = '0;
      if (ctrl.set_found) found_in = 1'b1;
      if (ctrl.st_set) begin
         status_in = ctrl.st;
         pos_in    = '0;
         found_in  = 1'b0;
      end

      // drop the taken result, then load a new one when the register frees
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (ctrl.emit && out_free) begin
         rsp_valid_in    = 1'b1;
         rsp_status_in   = status_ff;
         rsp_found_in    = found_ff;
         rsp_position_in = POSITION_W'(pos_ff);
         rsp_count_in    = COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff         <= func_in;
      value_ff        <= value_in;
      index_ff        <= index_in;
      ptr_ff          <= ptr_in;
      pos_ff          <= pos_in;
      found_ff        <= found_in;
      status_ff       <= status_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= rsp_count_in;
   end

   // Entry store: append writes at the tail, compaction moves an entry down.
   assign ram_wr_en   = ctrl.wr_tail || ctrl.wr_shift;
   assign ram_wr_addr = ctrl.wr_tail ? count_ff[ADDR_W-1:0] : ptr_ff[ADDR_W-1:0];
   assign ram_wr_data = ctrl.wr_tail ? value_ff : ram_rd_data;
   assign ram_rd_en   = ctrl.rd_cur || ctrl.rd_nxt;
   assign ram_rd_addr = ctrl.rd_nxt ? ptr_nxt[ADDR_W-1:0] : ptr_ff[ADDR_W-1:0];

   olsd_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;

   // the count never runs past the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} <= (CNT_W + 1)'(CAPACITY))
      else $error("entry count exceeds capacity");

   // a shift only ever moves an entry that lies below the count
   a_shift_in_list: assert property (@(posedge clock) disable iff (reset)
      ctrl.wr_shift |-> ((ptr_ff + (CNT_W + 1)'(1)) < {1'b0, count_ff}))
      else $error("compaction write outside the list");

   // a result loaded by the emit step is shown on the next cycle
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == S_EMIT && out_free) |=> (rsp_valid_ff && upc_ff == S_IDLE))
      else $error("emit step did not produce a result");

   // a reported match always carries a good status
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_status_ff == ST_OK))
      else $error("found flag with failure status");

endmodule
